>>> rtl/eft_pkg.sv
`timescale 1ns / 1ps

package eft_pkg;

    // event key: thread, instruction, visit
    localparam int KEY_W   = 56;
    localparam int COUNT_W = 32;
    localparam int DIST_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // request kinds carried on the input tuser
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;

    // one stored edge
    typedef struct packed {
        key_t   src;
        key_t   dst;
        count_t cnt;
    } entry_t;

    // compare result of the shared unit
    typedef struct packed {
        logic src_hit;
        logic edge_hit;
    } match_t;

endpackage

>>> rtl/eft_match_acc.sv
`timescale 1ns / 1ps

// shared key compare and saturating accumulate unit
module eft_match_acc
(
    input  eft_pkg::entry_t entry,
    input  eft_pkg::key_t   src_key,
    input  eft_pkg::key_t   dst_key,
    input  logic            scan_mode,
    input  eft_pkg::count_t acc,
    input  eft_pkg::count_t extra,
    output eft_pkg::match_t match,
    output eft_pkg::count_t acc_sum
);
    import eft_pkg::*;

    count_t             addend;
    logic [COUNT_W:0]   wide;

    // key compare against the stored entry
    always_comb
    begin
        match.src_hit  = (entry.src == src_key);
        match.edge_hit = (entry.src == src_key) && (entry.dst == dst_key);
    end

    // during the scan add the entry count on a source hit, otherwise the extra term
    assign addend  = scan_mode ? (match.src_hit ? entry.cnt : '0) : extra;
    assign wide    = {1'b0, acc} + {1'b0, addend};
    assign acc_sum = wide[COUNT_W] ? COUNT_MAX : wide[COUNT_W-1:0];

endmodule

>>> rtl/edge_frequency_table.sv
`timescale 1ns / 1ps

// channel   dir  tdata fields (lsb first)                               tuser
// s_*       in   from_thread, from_instruction, from_visit,              operation
//                to_thread, to_instruction, to_visit
// m_*       out  edge_count, source_sum, distinct_edges, zero pad       is_new, table_full
//
// each item is accepted, then the scan walks the N stored edges through the entry
// memory's single read port one entry a cycle, and the update step writes the
// count back and forms the result
// edges fill the memory in order, so the fill count marks which entries are valid
// reset clears the fill count and control at once; there is no clearing pass
// a result waits in the output register while the next item is taken; the
// update cycle holds until that register is free

module edge_frequency_table
#(
    parameter int EDGE_ENTRIES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // from_thread, from_instruction, from_visit,
                                   // to_thread, to_instruction, to_visit
    input  logic [0:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,  // edge_count, source_sum, distinct_edges, pad
    output logic [1:0]   m_tuser   // is_new, table_full
);
    import eft_pkg::*;

    localparam int AW = (EDGE_ENTRIES > 1) ? $clog2(EDGE_ENTRIES) : 1;
    localparam int TW = $clog2(EDGE_ENTRIES + 1);
    localparam logic [TW-1:0] ENTRIES_T = TW'(EDGE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [TW-1:0]  idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic           hit_reg, hit_next;
    logic [AW-1:0]  hit_idx_reg, hit_idx_next;
    count_t         hit_cnt_reg, hit_cnt_next;
    count_t         sum_reg, sum_next;
    logic           op_reg, op_next;
    key_t           src_reg, src_next;
    key_t           dst_reg, dst_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [79:0]    m_tdata_reg, m_tdata_next;
    logic [1:0]     m_tuser_reg, m_tuser_next;

    entry_t         mem [EDGE_ENTRIES];
    entry_t         rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;

    logic           scan_mode;
    count_t         extra;
    match_t         match;
    count_t         acc_sum;

    // entry memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign scan_mode = (state_reg == ST_SCAN);

    eft_match_acc u_match_acc
    (
        .entry     (rdata_reg),
        .src_key   (src_reg),
        .dst_key   (dst_reg),
        .scan_mode (scan_mode),
        .acc       (sum_reg),
        .extra     (extra),
        .match     (match),
        .acc_sum   (acc_sum)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        sum_next      = sum_reg;
        op_next       = op_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = hit_idx_reg;
        wr_data       = '{src: src_reg, dst: dst_reg, cnt: '0};
        extra         = '0;

        // output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser[0];
                    src_next   = {s_tdata[7:0], s_tdata[39:8], s_tdata[55:40]};
                    dst_next   = {s_tdata[63:56], s_tdata[95:64], s_tdata[111:96]};
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    sum_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue the next read while entries remain
                if (idx_reg != total_reg)
                begin
                    idx_next    = idx_reg + TW'(1);
                    pend_next   = 1'b1;
                    rd_idx_next = idx_reg[AW-1:0];
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
                // accumulate the entry read last cycle
                if (pend_reg)
                begin
                    sum_next = acc_sum;
                    if (match.edge_hit)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        hit_cnt_next = rdata_reg.cnt;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tuser_next = 2'b00;
                    if (op_reg == OP_RECORD)
                    begin
                        if (hit_reg)
                        begin
                            // known edge, saturating increment
                            wr_en   = 1'b1;
                            wr_addr = hit_idx_reg;
                            if (hit_cnt_reg != COUNT_MAX)
                            begin
                                wr_data.cnt = hit_cnt_reg + 32'd1;
                                extra       = 32'd1;
                            end
                            else
                            begin
                                wr_data.cnt = hit_cnt_reg;
                            end
                            m_tdata_next[31:0] = wr_data.cnt;
                        end
                        else if (total_reg != ENTRIES_T)
                        begin
                            // new edge goes to the next free slot
                            wr_en              = 1'b1;
                            wr_addr            = total_reg[AW-1:0];
                            wr_data.cnt        = 32'd1;
                            extra              = 32'd1;
                            total_next         = total_reg + TW'(1);
                            m_tuser_next[0]    = 1'b1;
                            m_tdata_next[31:0] = 32'd1;
                        end
                        else
                        begin
                            // no room left
                            m_tuser_next[1]    = 1'b1;
                            m_tdata_next[31:0] = '0;
                        end
                    end
                    else
                    begin
                        m_tdata_next[31:0] = hit_reg ? hit_cnt_reg : '0;
                    end
                    m_tdata_next[63:32] = acc_sum;
                    m_tdata_next[74:64] = DIST_W'(total_next);
                    m_tdata_next[79:75] = '0;
                    m_tvalid_next       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_cnt_reg <= hit_cnt_next;
        sum_reg     <= sum_next;
        op_reg      <= op_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ENTRIES_T)
    else $error("edge total beyond table size");

    // the scan never reads past the filled entries
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= total_reg)
    else $error("scan index beyond fill count");

    // at most one new edge per item
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != $past(total_reg) |-> total_reg == $past(total_reg) + TW'(1))
    else $error("edge total jumped");

    // a result never reports both a new edge and a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("new and full flagged together");

endmodule

>>> test/edge_frequency_table_test.sv
`timescale 1ns / 1ps

module edge_frequency_table_test;

    import eft_pkg::*;

    localparam int DEPTH = 1024;
    localparam int POOL  = 8;

    typedef logic [DIST_W-1:0] dist_t;

    // fields of one result item
    typedef struct packed {
        logic   is_new;
        count_t edge_count;
        count_t source_sum;
        dist_t  distinct_edges;
        logic   table_full;
    } edge_result_t;

    // one row of the directed table
    typedef struct {
        logic   op;
        key_t   src;
        key_t   dst;
        bit     typed;
        logic   is_new;
        count_t edge_count;
        count_t source_sum;
        dist_t  distinct_edges;
        logic   table_full;
    } request_row_t;

    localparam key_t KEY_A    = {8'h01, 32'h0000_1000, 16'h0001};
    localparam key_t KEY_B    = {8'h02, 32'h0000_2000, 16'h0002};
    localparam key_t KEY_C    = {8'h03, 32'h0000_3000, 16'h0003};
    localparam key_t KEY_D    = {8'h04, 32'h0000_4000, 16'h0004};
    localparam key_t KEY_ZERO = '0;
    localparam key_t KEY_ONES = '1;
    // keys one field away from KEY_A
    localparam key_t KEY_A_THR = {8'h81, 32'h0000_1000, 16'h0001};
    localparam key_t KEY_A_INS = {8'h01, 32'h8000_1000, 16'h0001};
    localparam key_t KEY_A_VIS = {8'h01, 32'h0000_1000, 16'h8001};

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // from_thread, from_instruction, from_visit,
                             // to_thread, to_instruction, to_visit
    logic [0:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;   // edge_count, source_sum, distinct_edges, pad
    logic [1:0]   m_tuser;   // is_new, table_full

    // shadow copy of the edge table
    key_t   stored_src [DEPTH];
    key_t   stored_dst [DEPTH];
    count_t stored_count [DEPTH];
    int     stored_edges;

    edge_result_t pending_results[$];
    edge_result_t oldest_result;
    request_row_t directed[$];
    key_t         src_pool [POOL];
    key_t         dst_pool [POOL];
    int           send_idle;
    int           recv_idle;
    int           errors = 0;

    edge_frequency_table #(.EDGE_ENTRIES(DEPTH)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    // table update and result for one request
    function automatic edge_result_t tally_edge(logic op, key_t src, key_t dst);
        edge_result_t     r;
        int               slot;
        logic [COUNT_W:0] sum;
        r = '0;
        slot = -1;
        sum = '0;
        for (int i = 0; i < stored_edges; i++)
        begin
            if (stored_src[i] == src && stored_dst[i] == dst)
                slot = i;
        end
        if (op == OP_RECORD)
        begin
            if (slot >= 0)
            begin
                if (stored_count[slot] != COUNT_MAX)
                    stored_count[slot] = stored_count[slot] + 1'b1;
                r.edge_count = stored_count[slot];
            end
            else if (stored_edges < DEPTH)
            begin
                stored_src[stored_edges] = src;
                stored_dst[stored_edges] = dst;
                stored_count[stored_edges] = 1;
                stored_edges++;
                r.is_new = 1'b1;
                r.edge_count = 1;
            end
            else
            begin
                r.table_full = 1'b1;
            end
        end
        else if (slot >= 0)
        begin
            r.edge_count = stored_count[slot];
        end
        // saturating sum over the source
        for (int i = 0; i < stored_edges; i++)
        begin
            if (stored_src[i] == src)
            begin
                sum = sum + stored_count[i];
                if (sum > COUNT_MAX)
                    sum = {1'b0, COUNT_MAX};
            end
        end
        r.source_sum = sum[COUNT_W-1:0];
        r.distinct_edges = dist_t'(stored_edges);
        return r;
    endfunction

    function automatic key_t random_key();
        return {8'($urandom), 32'($urandom), 16'($urandom)};
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // present one item, hold it until taken, then log its expectation
    task automatic send_request(logic op, key_t src, key_t dst, bit typed,
                                edge_result_t want);
        edge_result_t predicted;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dst[15:0], dst[47:16], dst[55:48], src[15:0], src[47:16], src[55:48]};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = tally_edge(op, src, dst);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // pool edges, fresh_pct percent fresh edges, some near misses and stray queries
    task automatic random_request(int fresh_pct);
        int   pick;
        logic op;
        key_t src;
        key_t dst;
        pick = $urandom_range(0, 99);
        src = src_pool[$urandom_range(0, POOL-1)];
        dst = dst_pool[$urandom_range(0, POOL-1)];
        op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_RECORD;
        if (pick < fresh_pct)
        begin
            if ($urandom_range(0, 1))
                src = random_key();
            dst = random_key();
            op = ($urandom_range(0, 9) == 0) ? OP_QUERY : OP_RECORD;
        end
        else if (pick < fresh_pct + 8)
        begin
            if ($urandom_range(0, 1))
                src = src ^ (key_t'(1) << $urandom_range(0, KEY_W-1));
            else
                dst = dst ^ (key_t'(1) << $urandom_range(0, KEY_W-1));
        end
        else if (pick < fresh_pct + 16)
        begin
            op = OP_QUERY;
            dst = random_key();
            if ($urandom_range(0, 1))
                src = random_key();
        end
        send_request(op, src, dst, 1'b0, '0);
    endtask

    // hold the sender off until every result is back
    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result check and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected");
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("is_new", 64'(oldest_result.is_new), 64'(m_tuser[0]));
                check_field("edge_count", 64'(oldest_result.edge_count),
                            64'(m_tdata[31:0]));
                check_field("source_sum", 64'(oldest_result.source_sum),
                            64'(m_tdata[63:32]));
                check_field("distinct_edges", 64'(oldest_result.distinct_edges),
                            64'(m_tdata[64 +: DIST_W]));
                check_field("table_full", 64'(oldest_result.table_full), 64'(m_tuser[1]));
            end
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        stored_edges = 0;
        send_idle = 7;
        recv_idle = 77;
        for (int i = 0; i < POOL; i++)
        begin
            src_pool[i] = random_key();
            dst_pool[i] = random_key();
        end

        // op, src, dst, typed, is_new, edge_count, source_sum, distinct_edges, table_full
        directed.push_back('{OP_QUERY,  KEY_A,     KEY_B,     1, 0, 0, 0, 0, 0});
        directed.push_back('{OP_RECORD, KEY_A,     KEY_B,     1, 1, 1, 1, 1, 0});
        directed.push_back('{OP_RECORD, KEY_A,     KEY_B,     1, 0, 2, 2, 1, 0});
        directed.push_back('{OP_QUERY,  KEY_A,     KEY_B,     1, 0, 2, 2, 1, 0});
        directed.push_back('{OP_RECORD, KEY_A,     KEY_C,     1, 1, 1, 3, 2, 0});
        directed.push_back('{OP_QUERY,  KEY_D,     KEY_B,     1, 0, 0, 0, 2, 0});
        directed.push_back('{OP_QUERY,  KEY_A,     KEY_D,     1, 0, 0, 3, 2, 0});
        directed.push_back('{OP_RECORD, KEY_ZERO,  KEY_ZERO,  1, 1, 1, 1, 3, 0});
        directed.push_back('{OP_RECORD, KEY_ONES,  KEY_ONES,  1, 1, 1, 1, 4, 0});
        directed.push_back('{OP_RECORD, KEY_ZERO,  KEY_ONES,  1, 1, 1, 2, 5, 0});
        directed.push_back('{OP_QUERY,  KEY_ONES,  KEY_ZERO,  1, 0, 0, 1, 5, 0});
        directed.push_back('{OP_RECORD, KEY_ONES,  KEY_ZERO,  1, 1, 1, 2, 6, 0});
        directed.push_back('{OP_RECORD, KEY_C,     KEY_A,     0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_RECORD, KEY_A_THR, KEY_B,     0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_RECORD, KEY_A_INS, KEY_B,     0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_RECORD, KEY_A_VIS, KEY_B,     0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_QUERY,  KEY_A_THR, KEY_B,     0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_RECORD, KEY_ZERO,  KEY_ZERO,  1, 0, 2, 3, 10, 0});
        directed.push_back('{OP_QUERY,  KEY_ONES,  KEY_ONES,  0, 0, 0, 0, 0, 0});
        directed.push_back('{OP_QUERY,  KEY_C,     KEY_A,     0, 0, 0, 0, 0, 0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
            send_request(directed[i].op, directed[i].src, directed[i].dst, directed[i].typed,
                         {directed[i].is_new, directed[i].edge_count, directed[i].source_sum,
                          directed[i].distinct_edges, directed[i].table_full});

        // receiver mostly stalled
        repeat (200) random_request(12);
        wait_for_quiet();

        // sender mostly idle
        send_idle = 77;
        recv_idle = 7;
        repeat (200) random_request(12);
        wait_for_quiet();

        // no idling: fill the table, then run into it full
        send_idle = 0;
        recv_idle = 0;
        while (stored_edges < DEPTH)
            random_request(90);
        repeat (30) random_request(50);

        wait_for_quiet();
        repeat (DEPTH + 8) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run time limit
    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/eft_pkg.sv
rtl/eft_match_acc.sv
rtl/edge_frequency_table.sv
test/edge_frequency_table_test.sv
